// ===== design/ins_sort_pkg.sv =====
// ----------------------------------------------------------------------------
// ins_sort_pkg
// Shared types and constants of the insertion sorter: item structs, the
// link between neighboring cells and the control state encoding.
// ----------------------------------------------------------------------------
package ins_sort_pkg;

   // number of cells in the sorting chain
   localparam int CAPACITY = 16;
   localparam int DATA_W   = 32;
   // fill count holds 0 .. CAPACITY
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // one input item
   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_type;

   // one result item
   typedef struct packed {
      logic signed [DATA_W-1:0] sorted_value;
      logic                     final_res;
      logic                     overflow;
   } rsp_type;

   // what one cell shows its neighbors
   typedef struct packed {
      logic                     occupied;
      logic                     gt;
      logic signed [DATA_W-1:0] data;
   } cell_link_type;

   // command broadcast to every cell
   typedef struct packed {
      logic                     insert_en;
      logic                     shift_en;
      logic signed [DATA_W-1:0] key;
   } cell_cmd_type;

   // controller states
   typedef enum logic {
      ST_LOAD,
      ST_DRAIN
   } state_type;

endpackage

// ===== design/ins_sort_cell.sv =====
// ----------------------------------------------------------------------------
// ins_sort_cell
// One place of the sorted chain. On insert it keeps its entry, takes the
// entry of its lower neighbor, or takes the new key; on shift it takes the
// entry of its upper neighbor.
// ----------------------------------------------------------------------------
module ins_sort_cell (
   input  logic                         clock,
   input  ins_sort_pkg::cell_cmd_type   cmd,
   input  logic                         occupied,
   input  ins_sort_pkg::cell_link_type  lower,
   input  ins_sort_pkg::cell_link_type  upper,
   output ins_sort_pkg::cell_link_type  link
);
   import ins_sort_pkg::*;

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;
   logic                     gt;

   // strictly greater, so equal keys land after earlier arrivals
   assign gt = occupied && (data_ff > cmd.key);

   // next entry
   always_comb begin
      data_in = data_ff;
      if (cmd.insert_en) begin
         if (gt || (!occupied && lower.occupied)) begin
            data_in = lower.gt ? lower.data : cmd.key;
         end
      end else if (cmd.shift_en) begin
         data_in = upper.data;
      end
   end

   // entry register, payload only
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign link.occupied = occupied;
   assign link.gt       = gt;
   assign link.data     = data_ff;

endmodule

// ===== design/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter
// Sorts a set of signed values into ascending order in a chain of cells and
// sends the set out smallest first after its last item.
//
//   channel   direction   payload     handshake
//   req_      in          req_type    req_valid / req_ready
//   rsp_      out         rsp_type    rsp_valid / rsp_ready
//
// On insert every cell compares the key in parallel and the larger entries
// move up one cell, so items of a set go in one per cycle. After the last
// item the set drains from cell zero, one result per cycle while rsp_ready
// is high; no item is taken during the drain. Reset empties the chain
// at once (fill count cleared). A stall on the result side holds the chain
// as it is.
// ----------------------------------------------------------------------------
module insertion_sorter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ins_sort_pkg::req_type req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ins_sort_pkg::rsp_type rsp_item
);
   import ins_sort_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;

   logic             req_fire;
   logic             rsp_fire;
   logic             full;
   logic             final_item;
   cell_cmd_type     cmd;

   cell_link_type    link  [CAPACITY];
   cell_link_type    lower [CAPACITY];
   cell_link_type    upper [CAPACITY];
   logic             occ   [CAPACITY];

   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign final_item = (count_ff == CNT_W'(1));
   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_item.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (rsp_fire && final_item) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_LOAD:  req_ready = 1'b1;
         ST_DRAIN: rsp_valid = 1'b1;
         default: begin
            req_ready = 1'b0;
            rsp_valid = 1'b0;
         end
      endcase
   end

   // fill count and dropped flag
   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (req_fire) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end else if (rsp_fire) begin
         count_in = count_ff - CNT_W'(1);
         if (final_item) begin
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   // command to the chain
   assign cmd.insert_en = req_fire && !full;
   assign cmd.shift_en  = rsp_fire;
   assign cmd.key       = req_item.value;

   // chain of cells, cell zero holds the smallest entry
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign occ[i] = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_low_end
         assign lower[i] = '{occupied: 1'b1, gt: 1'b0, data: '0};
      end else begin : g_low_link
         assign lower[i] = link[i-1];
      end

      if (i == CAPACITY - 1) begin : g_high_end
         assign upper[i] = '{occupied: 1'b0, gt: 1'b0, data: '0};
      end else begin : g_high_link
         assign upper[i] = link[i+1];
      end

      ins_sort_cell u_cell (
         .clock    (clock),
         .cmd      (cmd),
         .occupied (occ[i]),
         .lower    (lower[i]),
         .upper    (upper[i]),
         .link     (link[i])
      );
   end

   // result value comes straight from cell zero
   assign rsp_item.sorted_value = link[0].data;
   assign rsp_item.final_res    = final_item;
   assign rsp_item.overflow     = dropped_ff;

   // a drain never runs on an empty chain
   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (count_ff != '0))
      else $error("result offered with empty chain");

   // the final result leaves the block empty and loading
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_item.final_res) |=>
         (state_ff == ST_LOAD && count_ff == '0 && !dropped_ff))
      else $error("set not cleared after final result");

   // a last item starts a drain in the next cycle
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_item.last) |=> rsp_valid)
      else $error("no results after last item");

   // fill count stays within capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   // items are dropped only on a full chain
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> ($past(count_ff) == CNT_W'(CAPACITY)))
      else $error("item dropped with room left");

endmodule

// ===== verif/insertion_sorter_tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// insertion_sorter_tb
// Self-checking bench for the insertion sorter. Sets of signed values go in
// through the req_ channel; a local sorting model predicts the ascending
// results of every set and the rsp_ monitor checks them field by field.
// Both idle at random in phases 0 and 1; the receiver holds off once long
// enough to fill the chain; the sender waits for all results between phases.
// ----------------------------------------------------------------------------
module insertion_sorter_tb;
   import ins_sort_pkg::*;

   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PHASE_ITEMS   = 61;
   localparam int HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES = CAPACITY + 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_item  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_item;

   // items waiting to be offered and sorted results still due
   req_type pending_items[$];
   rsp_type expected_sorted[$];

   // sorting model state
   logic signed [DATA_W-1:0] sorted_model [CAPACITY];
   int                       stored_count   = 0;
   bit                       set_overflowed = 1'b0;

   int req_offered   = 0;
   int req_taken     = 0;
   int items_queued  = 0;
   int send_idle_pct = 17;
   int recv_idle_pct = 71;
   int hold_asked    = 0;
   int hold_granted  = 0;
   int hold_left     = 0;
   int fail_count    = 0;
   int cycle_count   = 0;

   insertion_sorter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // clock
   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // insert one accepted item, emit the whole set on its last item
   task automatic insert_and_emit(input req_type item);
      logic signed [DATA_W-1:0] key;
      int                       pos;
      rsp_type                  res;
      key = item.value;
      if (stored_count < CAPACITY) begin
         pos = stored_count;
         // larger entries move up, equal ones stay below the new key
         while (pos > 0 && sorted_model[pos-1] > key) begin
            sorted_model[pos] = sorted_model[pos-1];
            pos--;
         end
         sorted_model[pos] = key;
         stored_count++;
      end else begin
         set_overflowed = 1'b1;
      end
      if (item.last) begin
         for (int k = 0; k < stored_count; k++) begin
            res.sorted_value = sorted_model[k];
            res.final_res    = (k == stored_count - 1);
            res.overflow     = set_overflowed;
            expected_sorted.push_back(res);
         end
         stored_count   = 0;
         set_overflowed = 1'b0;
      end
   endtask

   task automatic add_item(input logic [DATA_W-1:0] value, input bit last);
      req_type item;
      item.value = value;
      item.last  = last;
      pending_items.push_back(item);
      items_queued++;
   endtask

   // one set of random values: wide, clustered with repeats, or extremes
   task automatic add_set(input int len);
      logic [DATA_W-1:0] v;
      for (int i = 0; i < len; i++) begin
         case ($urandom_range(0, 3))
            0, 1: v = $urandom;
            2: v = $urandom_range(0, 6) - 3;
            default: begin
               case ($urandom_range(0, 3))
                  0: v = 32'h8000_0000;
                  1: v = 32'h7fff_ffff;
                  2: v = '0;
                  default: v = '1;
               endcase
            end
         endcase
         add_item(v, i == len - 1);
      end
   endtask

   // drive input items at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken == req_offered) begin
         if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_item    <= pending_items.pop_front();
            req_valid   <= 1'b1;
            req_offered <= req_offered + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result ready: random idling, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_granted != hold_asked) begin
         rsp_ready    <= 1'b0;
         hold_left    <= HOLD_CYCLES;
         hold_granted <= hold_granted + 1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // sample both channels at the rising edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            insert_and_emit(req_item);
            req_taken <= req_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_sorted.size() == 0) begin
               $error("result item with none expected: sorted_value %0d",
                      rsp_item.sorted_value);
               fail_count++;
            end else begin
               want = expected_sorted.pop_front();
               if (rsp_item.sorted_value !== want.sorted_value) begin
                  $error("sorted_value: expected %0d, got %0d",
                         want.sorted_value, rsp_item.sorted_value);
                  fail_count++;
               end
               if (rsp_item.final_res !== want.final_res) begin
                  $error("final_res: expected %0b, got %0b",
                         want.final_res, rsp_item.final_res);
                  fail_count++;
               end
               if (rsp_item.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b",
                         want.overflow, rsp_item.overflow);
                  fail_count++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      int target;
      int r;
      int len;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-item sets at both extremes
      add_item(32'h7fff_ffff, 1'b1);
      add_item(32'h8000_0000, 1'b1);
      // repeats and extremes mixed in one set
      add_item(32'd3, 1'b0);
      add_item(32'hffff_ffff, 1'b0);
      add_item(32'h7fff_ffff, 1'b0);
      add_item(32'h8000_0000, 1'b0);
      add_item(32'hffff_ffff, 1'b0);
      add_item(32'd3, 1'b1);
      // descending set one past capacity, so the last item itself is dropped
      for (int i = 0; i <= CAPACITY; i++)
         add_item(40 - 5 * i, i == CAPACITY);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 71;
            end
            1: begin
               send_idle_pct = 71;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               // long hold-off while a full set streams in
               hold_asked++;
               add_set(CAPACITY);
               add_set(CAPACITY + 2);
            end
         endcase
         target = items_queued + PHASE_ITEMS;
         while (items_queued < target) begin
            r = $urandom_range(0, 19);
            if (r < 2)
               len = CAPACITY + $urandom_range(1, 5);
            else if (r == 2)
               len = CAPACITY;
            else if (r < 7)
               len = 1;
            else
               len = $urandom_range(2, CAPACITY - 1);
            add_set(len);
         end
         // sender pauses until every result of the phase is back
         while (pending_items.size() != 0 || req_taken != req_offered ||
                expected_sorted.size() != 0)
            @(posedge clock);
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_sorted.size() != 0)
         $error("%0d result items never arrived", expected_sorted.size());
      if (fail_count == 0 && expected_sorted.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
